[design/frop_pkg.sv]
// Shared types, sizes and codes of the object pool handle allocator.
package frop_pkg;

	localparam int POOL_SIZE   = 256;
	localparam int HANDLE_W    = 8;
	localparam int QUEUE_DEPTH = 1 << HANDLE_W;
	localparam int COUNT_W     = HANDLE_W + 1;
	localparam int POOL_LIMIT  = (POOL_SIZE < QUEUE_DEPTH) ? POOL_SIZE : QUEUE_DEPTH;

	typedef logic [HANDLE_W-1:0] handle_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [1:0]          action_t;
	typedef logic [1:0]          status_t;

	localparam action_t ACT_ALLOC   = 2'd0;
	localparam action_t ACT_TRY     = 2'd1;
	localparam action_t ACT_RELEASE = 2'd2;
	localparam action_t ACT_NONE    = 2'd3;

	localparam status_t STAT_OK         = 2'd0;
	localparam status_t STAT_NONE_FREED = 2'd1;
	localparam status_t STAT_EXHAUSTED  = 2'd2;
	localparam status_t STAT_UNTAKEN    = 2'd3;

	// Controller to datapath commands.
	typedef struct packed {
		logic    load_req;
		logic    pop;
		logic    fresh;
		logic    push;
		logic    res_load;
		status_t res_status;
		logic    out_load;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		action_t action;
		logic    queue_empty;
		logic    queue_full;
		logic    fresh_left;
		logic    taken_hit;
		logic    out_free;
	} sts_t;

endpackage

[design/frop_req_if.sv]
// Request channel interface: valid/ready handshake with action and handle.
interface frop_req_if;
	logic              valid;
	logic              ready;
	frop_pkg::action_t action;
	frop_pkg::handle_t handle_in;

	modport source (output valid, output action, output handle_in, input ready);
	modport sink   (input valid, input action, input handle_in, output ready);
endinterface

[design/frop_rsp_if.sv]
// Response channel interface: valid/ready handshake with handle and status.
interface frop_rsp_if;
	logic              valid;
	logic              ready;
	frop_pkg::handle_t handle_out;
	frop_pkg::status_t status;

	modport source (output valid, output handle_out, output status, input ready);
	modport sink   (input valid, input handle_out, input status, output ready);
endinterface

[design/fifo_reuse_object_pool_unit.sv]
// Top level of the object pool handle allocator: free-list FIFO with fresh-handle fallback.
// An accepted request moves through the request registers, the result register and the
// output register, and waits in the output register until the sink takes it.
// A new request is taken only after the last one is through accept, execute and hand-off,
// set by the controller sequence and the registered free-list RAM and taken bitmap reads.
// Reset: arst_n clears pointers, counters and the taken bitmap; the free-list RAM is left as is.
module fifo_reuse_object_pool_unit (
	input logic     clk,
	input logic     arst_n,
	frop_req_if.sink   req,
	frop_rsp_if.source rsp
);
	import frop_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Controller: IDLE takes a request, EXEC decides and updates the pool state,
	// OUT moves the result into the output register once it is free.
	frop_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: the free-list RAM always reads at the head, so the oldest freed
	// handle is ready by the time the execute step needs it.
	frop_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_action (req.action),
		.req_handle (req.handle_in),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.rsp_handle (rsp.handle_out),
		.rsp_status (rsp.status)
	);
endmodule

[design/frop_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module frop_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

[design/frop_dpath.sv]
// Datapath: request registers, free FIFO, taken bitmap, fresh counter, result registers.
module frop_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  frop_pkg::cmd_t    cmd,
	output frop_pkg::sts_t    sts,
	input  frop_pkg::action_t req_action,
	input  frop_pkg::handle_t req_handle,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output frop_pkg::handle_t rsp_handle,
	output frop_pkg::status_t rsp_status
);
	import frop_pkg::*;

	action_t   action_q;
	handle_t   handle_q;
	logic      taken_hit_q;
	handle_t   head_q;
	handle_t   tail_q;
	count_t    count_q;
	count_t    fresh_q;
	logic      taken_q [QUEUE_DEPTH];
	handle_t   rd_data;
	handle_t   fresh_handle;
	handle_t   taken_addr;
	handle_t   res_handle_q;
	status_t   res_status_q;
	logic      out_valid_q;
	handle_t   out_handle_q;
	status_t   out_status_q;

	frop_ram #(.WIDTH(HANDLE_W), .DEPTH(QUEUE_DEPTH)) u_free_queue (
		.clk     (clk),
		.wr_en   (cmd.push),
		.wr_addr (tail_q),
		.wr_data (handle_q),
		.rd_addr (head_q),
		.rd_data (rd_data)
	);

	assign fresh_handle = fresh_q[HANDLE_W-1:0];

	always_comb begin
		priority if (cmd.pop) begin
			taken_addr = rd_data;
		end else if (cmd.fresh) begin
			taken_addr = fresh_handle;
		end else begin
			taken_addr = handle_q;
		end
	end

	// Sample the taken bit with the request; the bitmap only changes in the execute step.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			action_q    <= req_action;
			handle_q    <= req_handle;
			taken_hit_q <= taken_q[req_handle];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			fresh_q <= '0;
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				taken_q[i] <= 1'b0;
			end
		end else begin
			if (cmd.pop) begin
				head_q  <= head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end else if (cmd.push) begin
				tail_q  <= tail_q + 1'b1;
				count_q <= count_q + 1'b1;
			end
			if (cmd.fresh) begin
				fresh_q <= fresh_q + 1'b1;
			end
			// Set on a grant, clear on a release.
			if (cmd.pop || cmd.fresh || cmd.push) begin
				taken_q[taken_addr] <= !cmd.push;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			priority if (cmd.pop) begin
				res_handle_q <= rd_data;
			end else if (cmd.fresh) begin
				res_handle_q <= fresh_handle;
			end else begin
				res_handle_q <= '0;
			end
		end
		if (cmd.out_load) begin
			out_handle_q <= res_handle_q;
			out_status_q <= res_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.action      = action_q;
	assign sts.queue_empty = (count_q == '0);
	assign sts.queue_full  = count_q[COUNT_W-1];
	assign sts.fresh_left  = (fresh_q < COUNT_W'(POOL_LIMIT));
	assign sts.taken_hit   = taken_hit_q;
	assign sts.out_free    = !out_valid_q || rsp_ready;

	assign rsp_valid  = out_valid_q;
	assign rsp_handle = out_handle_q;
	assign rsp_status = out_status_q;
endmodule

[design/frop_ctrl.sv]
// Controller: sequences each request through accept, execute and result hand-off.
module frop_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  frop_pkg::sts_t sts,
	output frop_pkg::cmd_t cmd
);
	import frop_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.res_load   = 1'b1;
				cmd.res_status = STAT_OK;
				unique case (sts.action)
					ACT_ALLOC, ACT_TRY: begin
						priority if (!sts.queue_empty) begin
							cmd.pop = 1'b1;
						end else if (sts.action == ACT_TRY) begin
							cmd.res_status = STAT_NONE_FREED;
						end else if (sts.fresh_left) begin
							cmd.fresh = 1'b1;
						end else begin
							cmd.res_status = STAT_EXHAUSTED;
						end
					end
					ACT_RELEASE: begin
						if (!sts.taken_hit || sts.queue_full) begin
							cmd.res_status = STAT_UNTAKEN;
						end else begin
							cmd.push = 1'b1;
						end
					end
					default: begin
					end
				endcase
				state_d = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
